[design/cce_pkg.sv]
// Shared types, codes and the color palette for the text console cursor engine.
// No dependencies; imported by cce_step and text_console_cursor_engine_top.
`timescale 1ns / 1ps
`default_nettype none

package cce_pkg;

  // Control bytes
  localparam logic [7:0] CH_BACKSPACE  = 8'h08;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_COLOUR_ESC = 8'hFE;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMNS    = 2'd0;
  localparam logic [1:0] REG_ROWS       = 2'd1;
  localparam logic [1:0] REG_CLEAR_CODE = 2'd2;

  // Configuration reset values
  localparam logic [8:0] COLUMNS_RST    = 9'd80;
  localparam logic [7:0] ROWS_RST       = 8'd25;
  localparam logic [7:0] CLEAR_CODE_RST = 8'd12;
  localparam logic [7:0] COLOUR_IDX_RST = 8'd1;

  // Display command codes
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_DRAW   = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_SCROLL = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef struct packed {
    logic [8:0] columns;
    logic [7:0] rows;
    logic [7:0] clear_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0] col;
    logic [6:0] row;
    logic [7:0] colour_index;
    logic       await_colour;
  } cursor_state_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  cell_x;
    logic [6:0]  cell_y;
    logic [7:0]  glyph;
    logic [23:0] glyph_colour;
  } cmd_t;

  // Palette lookup; unlisted indexes are black
  function automatic logic [23:0] rgb_of(input logic [7:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      8'd1:    rgb = 24'h989898;
      8'd2:    rgb = 24'hFFFFFF;
      8'd3:    rgb = 24'h0080FF;
      8'd4:    rgb = 24'h008000;
      8'd5:    rgb = 24'hFF5050;
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

[design/cce_step.sv]
// Single-pass decode of one console byte: next cursor state and display commands.
// Depends on cce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cce_step import cce_pkg::*; (
  input  wire logic [7:0]    char_byte,
  input  wire cfg_t          cfg,
  input  wire cursor_state_t cur,
  output cursor_state_t      nxt,
  output cmd_t               cmd,
  output logic               scroll_after
);

  logic [8:0] eff_cols;
  logic [7:0] eff_rows;
  logic [7:0] last_col;
  logic [6:0] last_row;
  logic       col_wrap;
  logic       row_fits;

  // Saturate the geometry registers into their used ranges
  always_comb begin
    if (cfg.columns == 9'd0) begin
      eff_cols = 9'd1;
    end else if (cfg.columns > 9'd256) begin
      eff_cols = 9'd256;
    end else begin
      eff_cols = cfg.columns;
    end
    if (cfg.rows == 8'd0) begin
      eff_rows = 8'd1;
    end else if (cfg.rows > 8'd128) begin
      eff_rows = 8'd128;
    end else begin
      eff_rows = cfg.rows;
    end
  end

  assign last_col = 8'(eff_cols - 9'd1);
  assign last_row = 7'(eff_rows - 8'd1);
  assign col_wrap = ({1'b0, cur.col} + 9'd1) >= eff_cols;
  assign row_fits = ({1'b0, cur.row} + 8'd1) < eff_rows;

  // Decode in priority order: pending escape, backspace, newline, clear, escape, glyph
  always_comb begin
    nxt          = cur;
    cmd          = '{action: ACT_NONE, cell_x: 8'd0, cell_y: 7'd0,
                     glyph: 8'd0, glyph_colour: 24'd0};
    scroll_after = 1'b0;
    priority if (cur.await_colour) begin
      nxt.await_colour = 1'b0;
      nxt.colour_index = char_byte;
    end else if (char_byte == CH_BACKSPACE) begin
      if (cur.col != 8'd0) begin
        nxt.col    = cur.col - 8'd1;
        cmd.action = ACT_ERASE;
        cmd.cell_x = cur.col - 8'd1;
        cmd.cell_y = cur.row;
      end else if (cur.row != 7'd0) begin
        nxt.row    = cur.row - 7'd1;
        nxt.col    = last_col;
        cmd.action = ACT_ERASE;
        cmd.cell_x = last_col;
        cmd.cell_y = cur.row - 7'd1;
      end
    end else if (char_byte == CH_NEWLINE) begin
      nxt.col = 8'd0;
      if (row_fits) begin
        nxt.row = cur.row + 7'd1;
      end else begin
        nxt.row    = last_row;
        cmd.action = ACT_SCROLL;
      end
    end else if (char_byte == cfg.clear_code) begin
      nxt.col    = 8'd0;
      nxt.row    = 7'd0;
      cmd.action = ACT_CLEAR;
    end else if (char_byte == CH_COLOUR_ESC) begin
      nxt.await_colour = 1'b1;
    end else begin
      cmd.action       = ACT_DRAW;
      cmd.cell_x       = cur.col;
      cmd.cell_y       = cur.row;
      cmd.glyph        = char_byte;
      cmd.glyph_colour = rgb_of(cur.colour_index);
      if (col_wrap) begin
        nxt.col = 8'd0;
        if (row_fits) begin
          nxt.row = cur.row + 7'd1;
        end else begin
          nxt.row      = last_row;
          scroll_after = 1'b1;
        end
      end else begin
        nxt.col = cur.col + 8'd1;
      end
    end
  end

endmodule

`default_nettype wire

[design/text_console_cursor_engine_top.sv]
// A byte accepted at one edge shows its first result in the next cycle.
// Throughput: one byte per cycle while out_ready is high; a wrapping draw holds the
// output register for two transactions, so the next byte waits for the scroll.
// Reset (rst, synchronous): cursor at the origin, color index 1, no escape pending,
// columns 80, rows 25, clear code 12, output register empty.
// Top level of the text console cursor engine; depends on cce_pkg and cce_step.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine_top import cce_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  // character input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_byte,
  // display commands
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       action,
  output logic [7:0]       cell_x,
  output logic [6:0]       cell_y,
  output logic [7:0]       glyph,
  output logic [23:0]      glyph_colour,
  output logic [7:0]       cursor_x,
  output logic [6:0]       cursor_y,
  output logic [23:0]      cursor_colour,
  output logic             last
);

  cfg_t          cfg;
  cursor_state_t cur;
  cursor_state_t cur_next;
  cmd_t          cmd;
  logic          scroll_after;
  logic          scroll_pend;
  logic          load;
  logic          pop;
  action_t       action_q;

  // Accept when the output register is empty or drains its final result now
  assign in_ready = !out_valid || (out_ready && !scroll_pend);
  assign load     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  cce_step u_step (
    .char_byte    (char_byte),
    .cfg          (cfg),
    .cur          (cur),
    .nxt          (cur_next),
    .cmd          (cmd),
    .scroll_after (scroll_after)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns    <= COLUMNS_RST;
      cfg.rows       <= ROWS_RST;
      cfg.clear_code <= CLEAR_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS:    cfg.columns    <= cfg_data;
        REG_ROWS:       cfg.rows       <= cfg_data[7:0];
        REG_CLEAR_CODE: cfg.clear_code <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  // Cursor state and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.col          <= 8'd0;
      cur.row          <= 7'd0;
      cur.colour_index <= COLOUR_IDX_RST;
      cur.await_colour <= 1'b0;
      out_valid        <= 1'b0;
      scroll_pend      <= 1'b0;
    end else if (load) begin
      cur         <= cur_next;
      out_valid   <= 1'b1;
      scroll_pend <= scroll_after;
    end else if (pop) begin
      if (scroll_pend) begin
        scroll_pend <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; the pending scroll replaces the draw once it is taken
  always_ff @(posedge clk) begin
    if (load) begin
      action_q      <= cmd.action;
      cell_x        <= cmd.cell_x;
      cell_y        <= cmd.cell_y;
      glyph         <= cmd.glyph;
      glyph_colour  <= cmd.glyph_colour;
      cursor_x      <= cur_next.col;
      cursor_y      <= cur_next.row;
      cursor_colour <= rgb_of(cur_next.colour_index);
      last          <= !scroll_after;
    end else if (pop && scroll_pend) begin
      action_q     <= ACT_SCROLL;
      cell_x       <= 8'd0;
      cell_y       <= 7'd0;
      glyph        <= 8'd0;
      glyph_colour <= 24'd0;
      last         <= 1'b1;
    end
  end

  assign action = action_q;

  // A pending scroll always sits behind a shown, non-final draw
  a_pend_behind_draw: assert property (@(posedge clk) disable iff (rst)
    scroll_pend |-> (out_valid && action_q == ACT_DRAW && !last))
    else $error("scroll pending without a draw in the output register");

  // Taking the draw exposes the scroll as the final result
  a_scroll_follows: assert property (@(posedge clk) disable iff (rst)
    (scroll_pend && out_ready) |=> (out_valid && action_q == ACT_SCROLL && last))
    else $error("scroll did not follow a wrapping draw");

  // No byte is taken while a pending scroll is still owed
  a_no_load_on_pend: assert property (@(posedge clk) disable iff (rst)
    scroll_pend |-> !load)
    else $error("byte accepted while a scroll is pending");

  // A scroll leaves the cursor in column zero
  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action_q == ACT_SCROLL) |-> (cursor_x == 8'd0))
    else $error("scroll result with cursor off column zero");

endmodule

`default_nettype wire
